// ===== sv/assert_macros.svh =====
// Assertion macros shared by the framer RTL.
// Expects clk and rst_n to be visible in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== sv/smpf_pkg.sv =====
// Shared types and constants of the swashplate mixer / packet framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package smpf_pkg;

    // Frame layout
    localparam logic [7:0] FRAME_HEADER = 8'h01;
    localparam int         FRAME_LEN    = 8;
    localparam int         CHANNELS     = 6;

    localparam logic [2:0] POS_HEADER   = 3'd0;
    localparam logic [2:0] POS_THROTTLE = 3'd1;
    localparam logic [2:0] POS_LEFT     = 3'd2;
    localparam logic [2:0] POS_FRONT    = 3'd3;
    localparam logic [2:0] POS_RUDDER   = 3'd4;
    localparam logic [2:0] POS_SPARE    = 3'd5;
    localparam logic [2:0] POS_RIGHT    = 3'd6;
    localparam logic [2:0] POS_CHECKSUM = 3'd7;

    // Pulse width centres, microseconds
    localparam int SERVO_CENTRE    = 1500;
    localparam int TAIL_CENTRE     = 1300;
    localparam int SERVO_DIVISOR   = 6;
    localparam int SERVO_NUMERATOR = SERVO_DIVISOR * SERVO_CENTRE;

    // Floor division by six for values below 2^17: (x * 43691) >> 18
    localparam int         RECIP6_SHIFT = 18;
    localparam logic [15:0] RECIP6      = 16'((1 << RECIP6_SHIFT) / SERVO_DIVISOR + 1);

    // Command saturation limits
    localparam int LAT_LIMIT = 1000;
    localparam int LON_LIMIT = 2000;
    localparam int COL_LIMIT = 500;

    // Sign mask bits
    localparam int SIGN_LEFT  = 0;
    localparam int SIGN_FRONT = 1;
    localparam int SIGN_RIGHT = 2;

    // Field widths
    localparam int WIDTH_W = 12;
    localparam int GAIN_W  = 24;
    localparam int NUM_W   = 15;
    localparam int PROD_W  = WIDTH_W + GAIN_W;
    localparam int FRAC_W  = 16;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH_FLOOR  = 2'd0,
        CFG_MAP_GAIN     = 2'd1,
        CFG_BYTE_CEILING = 2'd2,
        CFG_SIGN_MASK    = 2'd3
    } cfg_reg_t;

    localparam logic [11:0] WIDTH_FLOOR_RST  = 12'd1000;
    localparam logic [23:0] MAP_GAIN_RST     = 24'd16712;
    localparam logic [7:0]  BYTE_CEILING_RST = 8'd255;
    localparam logic [2:0]  SIGN_MASK_RST    = 3'd0;

    typedef struct packed {
        logic [11:0] width_floor;
        logic [23:0] map_gain;
        logic [7:0]  byte_ceiling;
        logic [2:0]  servo_sign_mask;
    } cfg_t;

    // Pulse widths of one command, all in 0..4095 us
    typedef struct packed {
        logic [11:0] throttle;
        logic [11:0] left;
        logic [11:0] front;
        logic [11:0] rudder;
        logic [11:0] right;
    } chan_widths_t;

endpackage

`default_nettype wire

// ===== sv/smpf_front.sv =====
// Front end: accepts a command, saturates and mixes it, forms the pulse widths.
// Depends on smpf_pkg; feeds smpf_queue.
`timescale 1ns / 1ps
`default_nettype none

module smpf_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic [11:0]          throttle_width,
    input  wire logic signed [10:0]   lateral_cmd,
    input  wire logic signed [11:0]   longitudinal_cmd,
    input  wire logic signed [9:0]    collective_cmd,
    input  wire logic signed [10:0]   rudder_cmd,
    input  wire logic [2:0]           sign_mask,
    output      logic                 push,
    output      smpf_pkg::chan_widths_t push_data,
    input  wire logic                 queue_ready
);

    import smpf_pkg::*;

    logic signed [10:0] lat_sat;
    logic signed [11:0] lon_sat;
    logic signed [9:0]  col_sat;
    logic signed [14:0] lat_x, lon_x, col6;
    logic signed [14:0] right_n, front_n, left_n;
    logic signed [14:0] right_s, front_s, left_s;
    logic signed [15:0] right_sum, front_sum, left_sum;
    logic signed [12:0] rudder_sum;

    logic               f1_valid_reg, f1_valid_next;
    logic [11:0]        thr_reg;
    logic [11:0]        rud_reg;
    logic [NUM_W-1:0]   left_x_reg, front_x_reg, right_x_reg;

    logic [30:0]        left_q, front_q, right_q;
    logic               load;

    // Saturate cyclic and collective commands
    always_comb
    begin
        if (lateral_cmd > 11'sd1000)
            lat_sat = 11'(LAT_LIMIT);
        else if (lateral_cmd < -11'sd1000)
            lat_sat = -11'(LAT_LIMIT);
        else
            lat_sat = lateral_cmd;

        if (longitudinal_cmd > 12'sd2000)
            lon_sat = 12'(LON_LIMIT);
        else if (longitudinal_cmd < -12'sd2000)
            lon_sat = -12'(LON_LIMIT);
        else
            lon_sat = longitudinal_cmd;

        if (collective_cmd > 10'sd500)
            col_sat = 10'(COL_LIMIT);
        else if (collective_cmd < -10'sd500)
            col_sat = -10'(COL_LIMIT);
        else
            col_sat = collective_cmd;
    end

    // Servo deltas in sixths, then sign and centre
    always_comb
    begin
        lat_x   = 15'(lat_sat);
        lon_x   = 15'(lon_sat);
        col6    = 15'sd6 * 15'(col_sat);
        right_n = col6 + 15'sd3 * lat_x - lon_x;
        front_n = col6 + 15'sd2 * lon_x;
        left_n  = col6 - 15'sd3 * lat_x - lon_x;

        right_s = sign_mask[SIGN_RIGHT] ? -right_n : right_n;
        front_s = sign_mask[SIGN_FRONT] ? -front_n : front_n;
        left_s  = sign_mask[SIGN_LEFT]  ? -left_n  : left_n;

        right_sum  = 16'(SERVO_NUMERATOR) + 16'(right_s);
        front_sum  = 16'(SERVO_NUMERATOR) + 16'(front_s);
        left_sum   = 16'(SERVO_NUMERATOR) + 16'(left_s);
        rudder_sum = 13'(TAIL_CENTRE) + 13'(rudder_cmd);
    end

    assign in_ready      = !f1_valid_reg || queue_ready;
    assign load          = in_valid && in_ready;
    assign push          = f1_valid_reg && queue_ready;
    assign f1_valid_next = load ? 1'b1 : (push ? 1'b0 : f1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= f1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            thr_reg     <= throttle_width;
            rud_reg     <= rudder_sum[11:0];
            left_x_reg  <= left_sum[NUM_W-1:0];
            front_x_reg <= front_sum[NUM_W-1:0];
            right_x_reg <= right_sum[NUM_W-1:0];
        end
    end

    // Divide the centred numerators by six, truncating (all are positive)
    always_comb
    begin
        left_q  = 31'(left_x_reg)  * 31'(RECIP6);
        front_q = 31'(front_x_reg) * 31'(RECIP6);
        right_q = 31'(right_x_reg) * 31'(RECIP6);

        push_data.throttle = thr_reg;
        push_data.left     = left_q[RECIP6_SHIFT +: WIDTH_W];
        push_data.front    = front_q[RECIP6_SHIFT +: WIDTH_W];
        push_data.rudder   = rud_reg;
        push_data.right    = right_q[RECIP6_SHIFT +: WIDTH_W];
    end

endmodule

`default_nettype wire

// ===== sv/smpf_queue.sv =====
// Short queue of pulse width sets between the front end and the frame builder.
// Depends on smpf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module smpf_queue #(
    parameter int DEPTH = smpf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire smpf_pkg::chan_widths_t push_data,
    output      logic                   push_ready,
    input  wire logic                   pop,
    output      logic                   head_valid,
    output      smpf_pkg::chan_widths_t head_data
);

    import smpf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    chan_widths_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_NEVER(a_no_overflow, push && count_reg == CNT_W'(DEPTH), "queue push while full")
    `ASSERT_NEVER(a_no_underflow, pop && count_reg == '0, "queue pop while empty")
    `ASSERT_CLK(a_count_up, push && !pop |=> count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

// ===== sv/smpf_back.sv =====
// Frame builder: maps each width to a channel byte and emits the 8-byte frame.
// Depends on smpf_pkg and assert_macros.svh; takes pulse widths from smpf_queue.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module smpf_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire smpf_pkg::cfg_t         cfg,
    input  wire logic                   head_valid,
    input  wire smpf_pkg::chan_widths_t head_data,
    output      logic                   pop,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic [7:0]             frame_byte,
    output      logic [2:0]             byte_index,
    output      logic                   frame_end
);

    import smpf_pkg::*;

    logic              advance;
    logic              issue;
    logic [2:0]        seq_idx_reg, seq_idx_next;
    logic [WIDTH_W-1:0] chan_w;
    logic [12:0]       diff;
    logic [PROD_W-1:0] prod;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_idx_reg;
    logic              m_neg_reg;
    logic [PROD_W-1:0] m_prod_reg;

    logic [PROD_W-FRAC_W-1:0] mapped;
    logic [7:0]        byte_calc;
    logic [7:0]        chk_reg;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [2:0]        out_idx_reg;

    // Whole pipeline holds while the output register is full and stalled
    assign advance = !out_valid_reg || out_ready;
    assign issue   = head_valid && advance;
    assign pop     = issue && (seq_idx_reg == POS_CHECKSUM);

    assign seq_idx_next   = issue ? seq_idx_reg + 3'd1 : seq_idx_reg;
    assign m_valid_next   = advance ? issue : m_valid_reg;
    assign out_valid_next = advance ? m_valid_reg : out_valid_reg;

    // Width of the channel at the current byte position
    always_comb
    begin
        unique case (seq_idx_reg)
            POS_THROTTLE: chan_w = head_data.throttle;
            POS_LEFT:     chan_w = head_data.left;
            POS_FRONT:    chan_w = head_data.front;
            POS_RUDDER:   chan_w = head_data.rudder;
            POS_SPARE:    chan_w = WIDTH_W'(TAIL_CENTRE);
            POS_RIGHT:    chan_w = head_data.right;
            default:      chan_w = '0;
        endcase
        diff = {1'b0, chan_w} - {1'b0, cfg.width_floor};
        prod = PROD_W'(diff[11:0]) * PROD_W'(cfg.map_gain);
    end

    // Clamp the scaled width into a channel byte
    always_comb
    begin
        mapped = m_prod_reg[PROD_W-1:FRAC_W];
        unique case (m_idx_reg)
            POS_HEADER:   byte_calc = FRAME_HEADER;
            POS_CHECKSUM: byte_calc = chk_reg;
            default:
            begin
                if (m_neg_reg)
                    byte_calc = 8'd0;
                else if (mapped > (PROD_W - FRAC_W)'(cfg.byte_ceiling))
                    byte_calc = cfg.byte_ceiling;
                else
                    byte_calc = mapped[7:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_idx_reg   <= POS_HEADER;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_idx_reg   <= seq_idx_next;
            m_valid_reg   <= m_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_idx_reg  <= seq_idx_reg;
            m_neg_reg  <= diff[12];
            m_prod_reg <= prod;
            if (m_valid_reg)
            begin
                out_byte_reg <= byte_calc;
                out_idx_reg  <= m_idx_reg;
                chk_reg      <= (m_idx_reg == POS_HEADER) ? byte_calc : chk_reg ^ byte_calc;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign frame_end  = out_idx_reg == POS_CHECKSUM;

    `ASSERT_CLK(a_idx_order, out_valid_reg && out_ready |=> !out_valid_reg || out_idx_reg == $past(out_idx_reg) + 3'd1, "frame bytes out of order")
    `ASSERT_CLK(a_frame_start, $rose(out_valid_reg) |-> out_idx_reg == POS_HEADER, "output resumed mid-frame")
    `ASSERT_CLK(a_stall_hold, m_valid_reg && !advance |=> m_valid_reg && $stable(m_idx_reg), "mapping stage lost a byte in a stall")

endmodule

`default_nettype wire

// ===== sv/swashplate_mix_packet_framer.sv =====
// CCPM 120 swashplate mixer and 8-byte packet framer, top level.
// Holds the configuration registers; instantiates smpf_front, smpf_queue, smpf_back.
//
// Use:
//   Command channel (in_valid/in_ready): one request carries throttle width and the
//   lateral, longitudinal, collective and rudder commands. The front end saturates
//   and mixes it into five pulse widths and queues them.
//   Byte channel (out_valid/out_ready): each command produces eight requests:
//   header 0x01, channel bytes throttle, left, front, rudder, spare, right, then the
//   XOR checksum. byte_index gives the position, frame_end marks the checksum.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 width floor,
//   1 map gain (Q8.16), 2 byte ceiling, 3 servo sign mask. Write only while idle.
// Timing:
//   The command passes the front-end register, the queue, and the builder's
//   mapping and output registers before its header appears. The builder emits
//   one byte per cycle while out_ready holds; that single byte port sets the
//   sustained rate; the queue takes the next commands while a frame is being sent.
// Reset clears the queue and pipeline and loads the register defaults.
// A receiver stall freezes the builder with the byte held; the queue then fills and
// in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module swashplate_mix_packet_framer #(
    parameter int QUEUE_DEPTH = smpf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [11:0]        throttle_width,
    input  wire logic signed [10:0] lateral_cmd,
    input  wire logic signed [11:0] longitudinal_cmd,
    input  wire logic signed [9:0]  collective_cmd,
    input  wire logic signed [10:0] rudder_cmd,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [7:0]         frame_byte,
    output      logic [2:0]         byte_index,
    output      logic               frame_end,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);

    import smpf_pkg::*;

    cfg_t         cfg_reg, cfg_next;
    logic         push;
    logic         push_ready;
    chan_widths_t push_data;
    logic         pop;
    logic         head_valid;
    chan_widths_t head_data;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Decode the register index and update the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_WIDTH_FLOOR:  cfg_next.width_floor     = cfg_data[11:0];
                CFG_MAP_GAIN:     cfg_next.map_gain        = cfg_data[23:0];
                CFG_BYTE_CEILING: cfg_next.byte_ceiling    = cfg_data[7:0];
                CFG_SIGN_MASK:    cfg_next.servo_sign_mask = cfg_data[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_floor     <= WIDTH_FLOOR_RST;
            cfg_reg.map_gain        <= MAP_GAIN_RST;
            cfg_reg.byte_ceiling    <= BYTE_CEILING_RST;
            cfg_reg.servo_sign_mask <= SIGN_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: saturate, mix, centre, divide by six
    smpf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .throttle_width   (throttle_width),
        .lateral_cmd      (lateral_cmd),
        .longitudinal_cmd (longitudinal_cmd),
        .collective_cmd   (collective_cmd),
        .rudder_cmd       (rudder_cmd),
        .sign_mask        (cfg_reg.servo_sign_mask),
        .push             (push),
        .push_data        (push_data),
        .queue_ready      (push_ready)
    );

    // Decouple command intake from byte emission
    smpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Back end: map widths to bytes, add header and checksum
    smpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
